>>> src/control_mode_lease_sequencer_assert.svh
// Assertion macros for the control-mode lease sequencer.
`ifndef CONTROL_MODE_LEASE_SEQUENCER_ASSERT_SVH
`define CONTROL_MODE_LEASE_SEQUENCER_ASSERT_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define CMLS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CMLS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define CMLS_ASSERT_SAME(label, clk, rst, ante, cons, msg)

`define CMLS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

>>> src/cmls_pkg.sv
`default_nettype none

package cmls_pkg;

   localparam int OWNER_BITS   = 8;
   localparam int EPOCH_BITS   = 16;
   localparam int LEASE_BITS   = 24;
   localparam int ELAPSED_BITS = LEASE_BITS + 1;
   localparam int REQ_ID_BITS  = 16;
   localparam int FAILURE_BITS = 8;

   localparam logic [1:0] MODE_NONE = 2'd0;

   typedef enum logic [2:0] {
      FUNC_REQUEST = 3'd0,
      FUNC_EVENT   = 3'd1,
      FUNC_FAIL    = 3'd2,
      FUNC_CANCEL  = 3'd3,
      FUNC_TICK    = 3'd4,
      FUNC_CHECK   = 3'd5
   } func_type;

   typedef enum logic [2:0] {
      EV_STOPPED         = 3'd0,
      EV_MOTION_CANCELED = 3'd1,
      EV_ARM_SAFE        = 3'd2,
      EV_BACKEND_ACTIVE  = 3'd3,
      EV_LEASE_CONFIRMED = 3'd4
   } event_type;

   typedef enum logic [2:0] {
      PH_IDLE       = 3'd0,
      PH_REQUESTED  = 3'd1,
      PH_CANCELING  = 3'd2,
      PH_VERIFYING  = 3'd3,
      PH_ACTIVATING = 3'd4,
      PH_CONFIRMING = 3'd5,
      PH_ACTIVE     = 3'd6,
      PH_FAILED     = 3'd7
   } phase_type;

   typedef enum logic [1:0] {
      REJECT_NONE  = 2'd0,
      REJECT_OWNER = 2'd1,
      REJECT_LEASE = 2'd2
   } reject_type;

   typedef struct packed {
      logic [2:0]              func;
      logic [1:0]              mode;
      logic [OWNER_BITS-1:0]   owner;
      logic [LEASE_BITS-1:0]   lease_ms;
      logic [2:0]              event_req;
      logic [EPOCH_BITS-1:0]   epoch_in;
      logic [FAILURE_BITS-1:0] failure_in;
   } item_type;

   typedef struct packed {
      logic                    accepted;
      logic [1:0]              reject_reason;
      logic [REQ_ID_BITS-1:0]  ticket;
      logic                    transition_error;
      logic [2:0]              phase_now;
      logic [1:0]              mode_now;
      logic [OWNER_BITS-1:0]   owner_now;
      logic [EPOCH_BITS-1:0]   epoch_now;
      logic                    lease_valid;
      logic                    command_allowed;
      logic [FAILURE_BITS-1:0] failure_now;
   } result_type;

   typedef struct packed {
      logic valid;
      logic ready;
   } stage_ctl_type;

endpackage

`default_nettype wire

>>> src/control_mode_lease_sequencer.sv
// Control-mode switch interlock with leases.
// The req_ channel carries one item per handshake: a request, an advance
// event, a fail, a cancel, a millisecond tick or a command check, chosen by
// req_func. The rsp_ channel returns exactly one result item for every
// accepted item, in order, with the status after that item is applied.
// An item is taken at a rising edge with valid high and stall low.
// An accepted item waits in the input register until the result register
// can take it; the state update then writes its result into the result
// register, and rsp_valid rises once that register is loaded.
// Throughput is one item per cycle while rsp_stall stays low; the state
// logic between the input and result registers is combinational.
// When the receiver stalls, the result register holds its item, the input
// register fills, and req_stall rises until the result is taken; no item
// is lost or repeated.
// A synchronous reset puts the phase in idle, clears modes, owners, the
// epoch, the failure code, lease timer and request counter, and empties
// both registers.
`default_nettype none

`include "control_mode_lease_sequencer_assert.svh"

module control_mode_lease_sequencer (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic [2:0]                           req_func,
   input  wire logic [1:0]                           req_mode,
   input  wire logic [cmls_pkg::OWNER_BITS-1:0]      req_owner,
   input  wire logic [cmls_pkg::LEASE_BITS-1:0]      req_lease_ms,
   input  wire logic [2:0]                           req_event_req,
   input  wire logic [cmls_pkg::EPOCH_BITS-1:0]      req_epoch_in,
   input  wire logic [cmls_pkg::FAILURE_BITS-1:0]    req_failure_in,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic                                      rsp_accepted,
   output logic [1:0]                                rsp_reject_reason,
   output logic [cmls_pkg::REQ_ID_BITS-1:0]          rsp_ticket,
   output logic                                      rsp_transition_error,
   output logic [2:0]                                rsp_phase_now,
   output logic [1:0]                                rsp_mode_now,
   output logic [cmls_pkg::OWNER_BITS-1:0]           rsp_owner_now,
   output logic [cmls_pkg::EPOCH_BITS-1:0]           rsp_epoch_now,
   output logic                                      rsp_lease_valid,
   output logic                                      rsp_command_allowed,
   output logic [cmls_pkg::FAILURE_BITS-1:0]         rsp_failure_now
);

   cmls_pkg::item_type      req_item;
   cmls_pkg::item_type      item;
   cmls_pkg::stage_ctl_type in_ctl;
   cmls_pkg::stage_ctl_type out_ctl;
   cmls_pkg::result_type    core_result;
   cmls_pkg::result_type    rsp_result;
   logic                    advance;

   assign req_item.func       = req_func;
   assign req_item.mode       = req_mode;
   assign req_item.owner      = req_owner;
   assign req_item.lease_ms   = req_lease_ms;
   assign req_item.event_req  = req_event_req;
   assign req_item.epoch_in   = req_epoch_in;
   assign req_item.failure_in = req_failure_in;

   assign advance = in_ctl.valid && out_ctl.ready;

   cmls_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .take      (advance),
      .ctl       (in_ctl),
      .item      (item)
   );

   cmls_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (item),
      .result (core_result)
   );

   cmls_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .result_in (core_result),
      .rsp_stall (rsp_stall),
      .ctl       (out_ctl),
      .result    (rsp_result)
   );

   assign rsp_valid            = out_ctl.valid;
   assign rsp_accepted         = rsp_result.accepted;
   assign rsp_reject_reason    = rsp_result.reject_reason;
   assign rsp_ticket           = rsp_result.ticket;
   assign rsp_transition_error = rsp_result.transition_error;
   assign rsp_phase_now        = rsp_result.phase_now;
   assign rsp_mode_now         = rsp_result.mode_now;
   assign rsp_owner_now        = rsp_result.owner_now;
   assign rsp_epoch_now        = rsp_result.epoch_now;
   assign rsp_lease_valid      = rsp_result.lease_valid;
   assign rsp_command_allowed  = rsp_result.command_allowed;
   assign rsp_failure_now      = rsp_result.failure_now;

   `CMLS_ASSERT_SAME(a_accept_phase, clock, reset, rsp_valid && rsp_accepted, rsp_phase_now == cmls_pkg::PH_REQUESTED && rsp_failure_now == '0, "accepted request did not enter requested")
   `CMLS_ASSERT_SAME(a_lease_active, clock, reset, rsp_valid && rsp_lease_valid, rsp_phase_now == cmls_pkg::PH_ACTIVE, "lease valid outside active phase")
   `CMLS_ASSERT_SAME(a_cmd_lease, clock, reset, rsp_valid && rsp_command_allowed, rsp_lease_valid && !rsp_accepted && !rsp_transition_error, "command allowed without a valid lease")
   `CMLS_ASSERT_NEXT(a_result_follows, clock, reset, advance, rsp_valid, "processed item produced no result")

endmodule

`default_nettype wire

>>> src/cmls_in_stage.sv
`default_nettype none

module cmls_in_stage (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire cmls_pkg::item_type req_item,
   input  wire logic              take,
   output cmls_pkg::stage_ctl_type ctl,
   output cmls_pkg::item_type      item
);

   logic               valid_ff;
   logic               valid_in;
   cmls_pkg::item_type item_ff;
   logic               accept;

   assign req_stall = valid_ff && !take;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_item;
      end
   end

   assign ctl.valid = valid_ff;
   assign ctl.ready = !req_stall;
   assign item      = item_ff;

endmodule

`default_nettype wire

>>> src/cmls_core.sv
`default_nettype none

module cmls_core (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               fire,
   input  wire cmls_pkg::item_type item,
   output cmls_pkg::result_type    result
);

   typedef struct packed {
      cmls_pkg::phase_type                    phase;
      logic [1:0]                             active_mode;
      logic [1:0]                             target_mode;
      logic [cmls_pkg::OWNER_BITS-1:0]        active_owner;
      logic [cmls_pkg::OWNER_BITS-1:0]        target_owner;
      logic [cmls_pkg::EPOCH_BITS-1:0]        epoch_count;
      logic [cmls_pkg::FAILURE_BITS-1:0]      stored_failure;
      logic [cmls_pkg::LEASE_BITS-1:0]        lease_timeout;
      logic [cmls_pkg::ELAPSED_BITS-1:0]      elapsed_ms;
      logic [cmls_pkg::REQ_ID_BITS-1:0]       request_counter;
   } state_type;

   state_type st_ff;
   state_type st_in;
   logic      ev_ok;
   logic      lease_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= '{phase: cmls_pkg::PH_IDLE, default: '0};
      end else if (fire) begin
         st_ff <= st_in;
      end
   end

   // Event k is only legal while the phase is k plus one.
   assign ev_ok = (item.event_req <= cmls_pkg::EV_LEASE_CONFIRMED) &&
                  ({1'b0, st_ff.phase} == ({1'b0, item.event_req} + 4'd1));

   always_comb begin
      st_in  = st_ff;
      result = '0;
      unique case (cmls_pkg::func_type'(item.func))
         cmls_pkg::FUNC_REQUEST: begin
            result.ticket         = st_ff.request_counter;
            st_in.request_counter = st_ff.request_counter + 1'b1;
            if (item.mode != cmls_pkg::MODE_NONE && item.owner == '0) begin
               result.reject_reason = cmls_pkg::REJECT_OWNER;
            end else if (item.mode != cmls_pkg::MODE_NONE && item.lease_ms == '0) begin
               result.reject_reason = cmls_pkg::REJECT_LEASE;
            end else begin
               result.accepted      = 1'b1;
               st_in.target_mode    = item.mode;
               st_in.target_owner   = item.owner;
               st_in.phase          = cmls_pkg::PH_REQUESTED;
               st_in.stored_failure = '0;
               st_in.lease_timeout  = item.lease_ms;
            end
         end
         cmls_pkg::FUNC_EVENT: begin
            if (!ev_ok) begin
               result.transition_error = 1'b1;
            end else if (item.event_req == cmls_pkg::EV_LEASE_CONFIRMED) begin
               st_in.active_mode  = st_ff.target_mode;
               st_in.active_owner = st_ff.target_owner;
               st_in.epoch_count  = st_ff.epoch_count + 1'b1;
               st_in.elapsed_ms   = '0;
               st_in.phase        = cmls_pkg::PH_ACTIVE;
            end else begin
               st_in.phase = cmls_pkg::phase_type'(item.event_req + 3'd2);
            end
         end
         cmls_pkg::FUNC_FAIL: begin
            st_in = '{phase: cmls_pkg::PH_FAILED, default: '0};
            st_in.epoch_count     = st_ff.epoch_count;
            st_in.request_counter = st_ff.request_counter;
            st_in.stored_failure  = item.failure_in;
         end
         cmls_pkg::FUNC_CANCEL: begin
            st_in = '{phase: cmls_pkg::PH_IDLE, default: '0};
            st_in.request_counter = st_ff.request_counter;
         end
         cmls_pkg::FUNC_TICK: begin
            if (st_ff.elapsed_ms != '1) begin
               st_in.elapsed_ms = st_ff.elapsed_ms + 1'b1;
            end
         end
         cmls_pkg::FUNC_CHECK: begin
         end
         default: begin
         end
      endcase

      lease_ok = (st_in.phase == cmls_pkg::PH_ACTIVE) &&
                 ((st_in.active_mode == cmls_pkg::MODE_NONE) ||
                  (st_in.elapsed_ms <= {1'b0, st_in.lease_timeout}));

      if (item.func == cmls_pkg::FUNC_CHECK) begin
         result.command_allowed = lease_ok &&
                                  (st_ff.active_mode == item.mode) &&
                                  (st_ff.active_owner == item.owner) &&
                                  (st_ff.epoch_count == item.epoch_in);
      end

      result.phase_now   = st_in.phase;
      result.mode_now    = st_in.active_mode;
      result.owner_now   = st_in.active_owner;
      result.epoch_now   = st_in.epoch_count;
      result.lease_valid = lease_ok;
      result.failure_now = st_in.stored_failure;
   end

endmodule

`default_nettype wire

>>> src/cmls_out_stage.sv
`default_nettype none

module cmls_out_stage (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 load,
   input  wire cmls_pkg::result_type result_in,
   input  wire logic                 rsp_stall,
   output cmls_pkg::stage_ctl_type   ctl,
   output cmls_pkg::result_type      result
);

   logic                 valid_ff;
   logic                 valid_in;
   cmls_pkg::result_type result_ff;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_stall) begin
         valid_in = valid_ff;
      end else begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result_in;
      end
   end

   assign ctl.valid = valid_ff;
   assign ctl.ready = !valid_ff || !rsp_stall;
   assign result    = result_ff;

endmodule

`default_nettype wire
